// File: design/vmaw_pkg.sv
// Shared types, codes and constants for the video memory access window.
package vmaw_pkg;

    // Request codes carried in the req_type field.
    localparam logic [2:0] REQ_VRAM_RD = 3'd0;
    localparam logic [2:0] REQ_VRAM_WR = 3'd1;
    localparam logic [2:0] REQ_OAM_RD  = 3'd2;
    localparam logic [2:0] REQ_OAM_WR  = 3'd3;
    localparam logic [2:0] REQ_PAL_RD  = 3'd4;
    localparam logic [2:0] REQ_PAL_WR  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DISPLAY_OFF = 2'd0;
    localparam logic [1:0] CFG_OVERSCAN    = 2'd1;
    localparam logic [1:0] CFG_INTERLACE   = 2'd2;
    localparam logic [1:0] CFG_PAL_REGION  = 2'd3;

    // Memory sizes that do not vary.
    localparam int OAM_BYTES     = 544;
    localparam int PALETTE_BYTES = 512;
    localparam int OAM_AW        = 10;
    localparam int PAL_AW        = 9;

    // Quotient of a 16-bit address by the smallest video RAM size.
    localparam int QUOT_W = 6;

    // Beam timing constants.
    localparam int LINES_NTSC = 525;
    localparam int LINES_PAL  = 625;
    localparam logic [8:0]  LAST_LINE_NTSC = 9'((LINES_NTSC >> 1) - 1);
    localparam logic [8:0]  LAST_LINE_PAL  = 9'((LINES_PAL >> 1) - 1);
    localparam logic [8:0]  VIS_RD_NORMAL  = 9'd224;
    localparam logic [8:0]  VIS_RD_OVER    = 9'd239;
    localparam logic [8:0]  VIS_WR_NORMAL  = 9'd225;
    localparam logic [8:0]  VIS_WR_OVER    = 9'd240;
    localparam logic [10:0] DOT_LAST       = 11'd1362;
    localparam logic [10:0] DOT_EARLY_MAX  = 11'd4;
    localparam logic [10:0] DOT_LATCH      = 11'd6;

    // Address masks.
    localparam logic [9:0] OAM_LOW_MASK  = 10'h3ff;
    localparam logic [9:0] OAM_HIGH_MASK = 10'h21f;
    localparam logic [7:0] PAL_ODD_MASK  = 8'h7f;

    // Operation that the back end carries out for one item.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_VRAM_RD = 3'd1,
        OP_VRAM_WR = 3'd2,
        OP_OAM_RD  = 3'd3,
        OP_OAM_WR  = 3'd4,
        OP_PAL_RD  = 3'd5,
        OP_PAL_WR  = 3'd6
    } t_op;

    // One classified item in the queue between front and back.
    typedef struct packed {
        t_op               op;
        logic [15:0]       addr;
        logic [QUOT_W-1:0] quot;
        logic [7:0]        data;
    } t_entry;

    // Object table index: in the upper half only bits 9 and 4..0 survive.
    function automatic logic [OAM_AW-1:0] obj_index(input logic [9:0] a);
        logic [9:0] x;
        x = a & OAM_LOW_MASK;
        if (x[9]) begin
            x = x & OAM_HIGH_MASK;
        end
        return x;
    endfunction

endpackage

// File: design/vmaw_if.sv
// Request and response channel interfaces of the video memory access window.
interface vmaw_req_if
    import vmaw_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] byte_addr;
    logic [7:0]  write_byte;
    logic [8:0]  beam_line;
    logic [10:0] beam_dot;
    logic        odd_field;
    logic [7:0]  bus_latch;
    logic [9:0]  oam_internal_addr;

    modport source (
        output valid, req_type, byte_addr, write_byte, beam_line, beam_dot,
               odd_field, bus_latch, oam_internal_addr,
        input  ready
    );
    modport sink (
        input  valid, req_type, byte_addr, write_byte, beam_line, beam_dot,
               odd_field, bus_latch, oam_internal_addr,
        output ready
    );
endinterface

interface vmaw_rsp_if
    import vmaw_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       write_done;

    modport source (output valid, read_byte, write_done, input ready);
    modport sink   (input valid, read_byte, write_done, output ready);
endinterface

// File: design/video_memory_access_window.sv
// Top level of the video memory access window: front end, queue and back end.
//
// The block takes one access item per clock cycle while the queue has room and
// returns its result through the two-entry queue behind the front end's beam
// gating and the single-port memory whose registered read data forms the
// response register. Sustained rate is one item per cycle when responses are
// taken, set by the one access each memory port makes per cycle. The memories
// are not cleared at reset; reading a never-written entry returns an undefined
// byte. Configuration writes take effect at the next clock edge; the user
// makes them while no item is in flight, which the block does not check.
module video_memory_access_window
    import vmaw_pkg::*;
#(
    parameter int VRAM_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic       i_cfg_data,
    vmaw_req_if.sink   i_req,
    vmaw_rsp_if.source o_rsp
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry push_entry;
    t_entry head_entry;

    // Accept and classify.
    vmaw_front #(
        .VRAM_BYTES(VRAM_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (i_req),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // Decoupling queue.
    vmaw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    // Memory access and response.
    vmaw_back #(
        .VRAM_BYTES(VRAM_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: design/vmaw_front.sv
// Front end: configuration registers, request acceptance and beam gating.
module vmaw_front
    import vmaw_pkg::*;
#(
    parameter int VRAM_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic             i_cfg_data,
    vmaw_req_if.sink         i_req,
    input  logic             i_full,
    output logic             o_push,
    output t_entry           o_entry
);

    // Floor reciprocal of the video RAM size, scaled by 2^32.
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / VRAM_BYTES);

    logic r_display_off;
    logic r_overscan;
    logic r_interlace;
    logic r_pal_region;

    logic [8:0]          vis_rd;
    logic [8:0]          vis_wr;
    logic [8:0]          last_line;
    logic                active;
    logic [15+RECIP_W:0] quot_prod;

    // Configuration registers, which the user must write only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_off <= 1'b1;
            r_overscan    <= 1'b0;
            r_interlace   <= 1'b0;
            r_pal_region  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DISPLAY_OFF: r_display_off <= i_cfg_data;
                CFG_OVERSCAN:    r_overscan    <= i_cfg_data;
                CFG_INTERLACE:   r_interlace   <= i_cfg_data;
                CFG_PAL_REGION:  r_pal_region  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // An item is taken whenever the queue has room.
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Beam limits for the current mode.
    always_comb begin
        vis_rd    = r_overscan ? VIS_RD_OVER : VIS_RD_NORMAL;
        vis_wr    = r_overscan ? VIS_WR_OVER : VIS_WR_NORMAL;
        last_line = (r_pal_region ? LAST_LINE_PAL : LAST_LINE_NTSC)
                  + 9'(r_interlace && !i_req.odd_field);
        active    = !r_display_off && (i_req.beam_line < vis_wr);
    end

    // Quotient estimate for the video RAM wrap; the back end corrects it.
    assign quot_prod = (16 + RECIP_W)'(i_req.byte_addr) * (16 + RECIP_W)'(RECIP);

    // Classify the request into one back-end operation.
    always_comb begin
        o_entry.op   = OP_NONE;
        o_entry.addr = i_req.byte_addr;
        o_entry.quot = quot_prod[32 +: QUOT_W];
        o_entry.data = i_req.write_byte;
        case (i_req.req_type)
            REQ_VRAM_RD: begin
                if (r_display_off) begin
                    o_entry.op = OP_VRAM_RD;
                end else if (i_req.beam_line == last_line && i_req.beam_dot == DOT_LAST) begin
                    o_entry.op = OP_NONE;
                end else if (i_req.beam_line < vis_rd) begin
                    o_entry.op = OP_NONE;
                end else if (i_req.beam_line == vis_rd) begin
                    o_entry.op = (i_req.beam_dot == DOT_LAST) ? OP_VRAM_RD : OP_NONE;
                end else begin
                    o_entry.op = OP_VRAM_RD;
                end
            end
            REQ_VRAM_WR: begin
                if (r_display_off) begin
                    o_entry.op = OP_VRAM_WR;
                end else if (i_req.beam_line == 9'd0) begin
                    // Early dots of line 0 still store; the latch dot stores open bus.
                    if (i_req.beam_dot <= DOT_EARLY_MAX) begin
                        o_entry.op = OP_VRAM_WR;
                    end else if (i_req.beam_dot == DOT_LATCH) begin
                        o_entry.op   = OP_VRAM_WR;
                        o_entry.data = i_req.bus_latch;
                    end
                end else if (i_req.beam_line < vis_wr) begin
                    o_entry.op = OP_NONE;
                end else if (i_req.beam_line == vis_wr) begin
                    o_entry.op = (i_req.beam_dot > DOT_EARLY_MAX) ? OP_VRAM_WR : OP_NONE;
                end else begin
                    o_entry.op = OP_VRAM_WR;
                end
            end
            REQ_OAM_RD, REQ_OAM_WR: begin
                o_entry.op   = (i_req.req_type == REQ_OAM_RD) ? OP_OAM_RD : OP_OAM_WR;
                o_entry.addr = 16'(obj_index(active ? i_req.oam_internal_addr
                                                    : i_req.byte_addr[9:0]));
            end
            REQ_PAL_RD: begin
                o_entry.op   = OP_PAL_RD;
                o_entry.addr = 16'(i_req.byte_addr[PAL_AW-1:0]);
            end
            REQ_PAL_WR: begin
                o_entry.op   = OP_PAL_WR;
                o_entry.addr = 16'(i_req.byte_addr[PAL_AW-1:0]);
                if (i_req.byte_addr[0]) begin
                    o_entry.data = i_req.write_byte & PAL_ODD_MASK;
                end
            end
            default: o_entry.op = OP_NONE;
        endcase
    end

    // With the display forced blank every video RAM write must store.
    a_blank_write_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_display_off && i_req.req_type == REQ_VRAM_WR)
        |-> (o_entry.op == OP_VRAM_WR))
        else $error("blanked video RAM write was dropped");

endmodule

// File: design/vmaw_fifo.sv
// Two-entry queue of classified items between front and back.
module vmaw_fifo
    import vmaw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int DEPTH = 2;

    t_entry     r_slot [DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_slot[r_rptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count out of range");

endmodule

// File: design/vmaw_back.sv
// Back end: memory access for each queued item and the response register.
module vmaw_back
    import vmaw_pkg::*;
#(
    parameter int VRAM_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_entry    i_entry,
    output logic      o_pop,
    vmaw_rsp_if.source o_rsp
);

    localparam int VAW = $clog2(VRAM_BYTES);
    localparam logic [16:0] VRAM_N = 17'(VRAM_BYTES);

    logic [7:0] r_vram [VRAM_BYTES];
    logic [7:0] r_oam  [OAM_BYTES];
    logic [7:0] r_pal  [PALETTE_BYTES];

    logic [7:0] r_vram_q;
    logic [7:0] r_oam_q;
    logic [7:0] r_pal_q;
    logic       r_out_valid;
    t_op        r_op;
    logic       r_pal_odd;

    logic [16:0]    quot_prod;
    logic [16:0]    wrap_diff;
    logic [16:0]    wrap_fix;
    logic [VAW-1:0] vram_idx;

    // Take the next item once the response register is free or being drained.
    assign o_pop = !i_empty && (!r_out_valid || o_rsp.ready);

    // Finish the video RAM wrap: one correction after the quotient estimate.
    always_comb begin
        quot_prod = 17'(i_entry.quot) * VRAM_N;
        wrap_diff = {1'b0, i_entry.addr} - quot_prod;
        wrap_fix  = (wrap_diff >= VRAM_N) ? (wrap_diff - VRAM_N) : wrap_diff;
        vram_idx  = wrap_fix[VAW-1:0];
    end

    // Video RAM port.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.op == OP_VRAM_WR) begin
            r_vram[vram_idx] <= i_entry.data;
        end
        if (o_pop && i_entry.op == OP_VRAM_RD) begin
            r_vram_q <= r_vram[vram_idx];
        end
    end

    // Object table port.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.op == OP_OAM_WR) begin
            r_oam[i_entry.addr[OAM_AW-1:0]] <= i_entry.data;
        end
        if (o_pop && i_entry.op == OP_OAM_RD) begin
            r_oam_q <= r_oam[i_entry.addr[OAM_AW-1:0]];
        end
    end

    // Palette port.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.op == OP_PAL_WR) begin
            r_pal[i_entry.addr[PAL_AW-1:0]] <= i_entry.data;
        end
        if (o_pop && i_entry.op == OP_PAL_RD) begin
            r_pal_q <= r_pal[i_entry.addr[PAL_AW-1:0]];
        end
    end

    // Response control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op      <= i_entry.op;
            r_pal_odd <= i_entry.addr[0];
        end
    end

    // Response payload from the memory read registers.
    assign o_rsp.valid = r_out_valid;
    always_comb begin
        o_rsp.read_byte  = 8'd0;
        o_rsp.write_done = 1'b0;
        case (r_op)
            OP_VRAM_RD: o_rsp.read_byte = r_vram_q;
            OP_OAM_RD:  o_rsp.read_byte = r_oam_q;
            OP_PAL_RD:  o_rsp.read_byte = r_pal_odd ? (r_pal_q & PAL_ODD_MASK) : r_pal_q;
            OP_VRAM_WR, OP_OAM_WR, OP_PAL_WR: o_rsp.write_done = 1'b1;
            default: ;
        endcase
    end

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_rsp.write_done) |-> (o_rsp.read_byte == 8'd0))
        else $error("write item returned read data");

    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_entry.op == OP_VRAM_RD || i_entry.op == OP_VRAM_WR))
        |-> (wrap_fix < VRAM_N))
        else $error("video RAM wrap left the index out of range");

endmodule
